// ===== design/sbda_pkg.sv =====
`default_nettype none
package sbda_pkg;

  // Default operand width
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // BCD digit and ASCII constants
  localparam int unsigned BCD_W      = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam logic [3:0]  BCD_ADJ_LIM = 4'd5;
  localparam logic [3:0]  BCD_ADJ_ADD = 4'd3;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;

  // Control handed from the sequencer to every digit cell
  typedef struct packed {
    logic clr;     // clear digit
    logic conv;    // double-dabble step: adjust, then shift in one bit
    logic dshift;  // take the digit of the lower neighbor
  } sbda_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/sbda_cell.sv =====
`default_nettype none
module sbda_cell (
  input  wire logic                   clk_i,
  input  wire sbda_pkg::sbda_cell_ctrl_t ctrl_i,
  input  wire logic                   bit_i,    // serial bit from lower neighbor
  input  wire logic [3:0]             digit_i,  // digit from lower neighbor
  output logic                        bit_o,    // carry into upper neighbor
  output logic [3:0]                  digit_o   // held digit
);
  import sbda_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add-3 correction before the shift keeps the digit decimal
  always_comb begin
    adj = (digit_q >= BCD_ADJ_LIM) ? (digit_q + BCD_ADJ_ADD) : digit_q;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    priority if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule
`default_nettype wire

// ===== design/signed_binary_to_decimal_ascii.sv =====
// Channel  | Direction | Ports                          | Handshake
// ---------+-----------+--------------------------------+-------------------------------
// command  | in        | value_i                        | start, busy (start & !busy)
// result   | out       | ascii_char_o, last_o           | valid_o strobe, one cycle each
//
// Steps: the double-dabble chain takes in one bit per cycle, then a minus
// sign goes out if the value is negative, then NDIG digits drain one per cycle.
// Busy rises once a transaction is taken and drops as the last character
// shows; no new transaction is taken while busy.
// Reset is asynchronous, active low, and returns the sequencer to idle.
// The receiver cannot stall: each character is shown for exactly one cycle.
`default_nettype none
module signed_binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output logic                        busy,
  output logic                        valid_o,
  output logic [7:0]                  ascii_char_o,
  output logic                        last_o
);
  import sbda_pkg::*;

  // Decimal digits of the largest magnitude 2^(VALUE_WIDTH-1)
  localparam int unsigned NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   started_q, started_d;
  logic                   valid_q, valid_d;
  logic                   last_q, last_d;
  logic [7:0]             char_q, char_d;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] mag_in;
  sbda_cell_ctrl_t        cell_ctrl;
  logic [NDIG:0]          bit_chain;
  logic [3:0]             digit_chain [NDIG+1];
  logic [3:0]             top_digit;
  logic                   top_nz;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Unsigned magnitude, exact for the most negative value
  assign mag_in = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Digit chain: cell 0 is least significant
  assign bit_chain[0]   = mag_q[VALUE_WIDTH-1];
  assign digit_chain[0] = '0;

  for (genvar g = 0; g < NDIG; g++) begin : g_cell
    sbda_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (bit_chain[g]),
      .digit_i (digit_chain[g]),
      .bit_o   (bit_chain[g+1]),
      .digit_o (digit_chain[g+1])
    );
  end

  assign top_digit = digit_chain[NDIG];
  assign top_nz    = (top_digit != '0);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    started_d = started_q;
    valid_d   = 1'b0;
    last_d    = 1'b0;
    char_d    = char_q;
    cell_ctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mag_d         = mag_in;
          neg_d         = value_i[VALUE_WIDTH-1];
          cnt_d         = CNT_W'(VALUE_WIDTH - 1);
          cell_ctrl.clr = 1'b1;
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.conv = 1'b1;
        mag_d          = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          cnt_d     = CNT_W'(NDIG - 1);
          started_d = 1'b0;
          state_d   = neg_q ? ST_SIGN : ST_OUT;
        end
      end
      ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = CHAR_MINUS;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Leading zeros are dropped; the units digit always goes out
        cell_ctrl.dshift = 1'b1;
        started_d        = started_q || top_nz;
        valid_d          = started_q || top_nz || (cnt_q == '0);
        last_d           = (cnt_q == '0);
        char_d           = CHAR_ZERO + {4'b0, top_digit};
        cnt_d            = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    char_q <= char_d;
  end

  assign valid_o      = valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  // Checks
  a_accept_to_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && (state_q == ST_CONV))
    else $error("accepted transaction did not start conversion");

  a_quiet_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !valid_o)
    else $error("character strobed during conversion");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> (ascii_char_o >= CHAR_ZERO) && (ascii_char_o <= 8'h39))
    else $error("final character is not a digit");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("block went idle before the final character");

endmodule
`default_nettype wire

// ===== sim/signed_binary_to_decimal_ascii_test.sv =====
`default_nettype none
module signed_binary_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW = sbda_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned DRAIN_CYCLES = 60;

  // one expected output character
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // one number waiting to be sent, with its sender pacing
  typedef struct {
    logic [VW-1:0] value;
    int unsigned   idle_pct;
    bit            hold;
  } number_item_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic [VW-1:0] value_i = '0;
  logic          busy;
  logic          valid_o;
  logic [7:0]    ascii_char_o;
  logic          last_o;

  number_item_t  number_q[$];
  text_char_t    exp_text_q[$];
  int unsigned   numbers_sent = 0;
  int unsigned   negatives_sent = 0;
  int unsigned   chars_checked = 0;
  int unsigned   mismatches = 0;

  signed_binary_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .value_i     (value_i),
    .busy        (busy),
    .valid_o     (valid_o),
    .ascii_char_o(ascii_char_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Decimal text of a signed number, most significant character first
  task automatic push_decimal_text(input logic [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [7:0]    digits[$];
    text_char_t    c;
    mag = v[VW-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(sbda_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[VW-1]) begin
      c.ch = sbda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      exp_text_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch = digits[i];
      c.last = (i == digits.size() - 1);
      exp_text_q.push_back(c);
    end
  endtask

  task automatic add_number(input logic [VW-1:0] v, input int unsigned pct, input bit hold);
    number_item_t it;
    it.value = v;
    it.idle_pct = pct;
    it.hold = hold;
    number_q.push_back(it);
  endtask

  // Random number: often with a bounded digit count so every text length shows up
  function automatic logic [VW-1:0] pick_number();
    longint lim;
    longint v;
    int unsigned kind;
    int unsigned nd;
    kind = $urandom_range(9);
    v = 0;
    if (kind <= 3) begin
      return $urandom;
    end else if (kind <= 7) begin
      nd = $urandom_range(1, 10);
      lim = 1;
      repeat (nd) lim = lim * 10;
      lim = lim - 1;
      if (lim > 64'sd2147483647) lim = 64'sd2147483647;
      v = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (lim + 1);
      if ($urandom_range(1)) v = -v;
    end else if (kind == 8) begin
      v = $urandom_range(1) ? (-64'sd2147483648 + $urandom_range(15))
                            : (64'sd2147483647 - $urandom_range(15));
    end else begin
      v = longint'($urandom_range(40)) - 20;
    end
    return v[VW-1:0];
  endfunction

  // Driver: one transaction is taken at each edge with start high and busy low
  always @(posedge clk_i) begin
    logic          nxt_start;
    logic [VW-1:0] nxt_value;
    number_item_t  nxt_item;
    nxt_start = start;
    nxt_value = value_i;
    if (rst_ni) begin
      if (start && !busy) begin
        push_decimal_text(value_i);
        numbers_sent++;
        if (value_i[VW-1]) negatives_sent++;
        nxt_start = 1'b0;
        nxt_value = $urandom;
      end else if (!start) begin
        nxt_value = $urandom;
      end
      if (!nxt_start && number_q.size() > 0) begin
        if (!(number_q[0].hold && exp_text_q.size() != 0) &&
            $urandom_range(99) >= number_q[0].idle_pct) begin
          nxt_start = 1'b1;
          nxt_item  = number_q.pop_front();
          nxt_value = nxt_item.value;
        end
      end
    end
    start <= nxt_start;
    value_i <= nxt_value;
  end

  // Monitor: every strobed character is checked against the oldest expectation
  always @(posedge clk_i) begin
    text_char_t e;
    if (rst_ni && valid_o) begin
      if (exp_text_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $realtime, ascii_char_o, last_o);
        mismatches++;
      end else begin
        e = exp_text_q.pop_front();
        chars_checked++;
        if (ascii_char_o !== e.ch || last_o !== e.last) begin
          $display("%0t: character mismatch: expected %h last %b, actual %h last %b",
                   $realtime, e.ch, e.last, ascii_char_o, last_o);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned pct_tab[4];
    pct_tab[0] = 0;
    pct_tab[1] = 68;
    pct_tab[2] = 0;
    pct_tab[3] = 31;

    // directed: zero, one-digit edges, powers of ten and neighbours, both extremes, bit patterns
    add_number(32'd0, 0, 1'b0);
    add_number(32'd1, 0, 1'b0);
    add_number(-32'sd1, 0, 1'b0);
    add_number(32'd9, 0, 1'b0);
    add_number(32'd10, 0, 1'b0);
    add_number(-32'sd10, 0, 1'b0);
    add_number(32'd99, 0, 1'b0);
    add_number(-32'sd100, 0, 1'b0);
    add_number(32'd999999999, 0, 1'b0);
    add_number(32'd1000000000, 0, 1'b0);
    add_number(-32'sd1000000000, 0, 1'b0);
    add_number(32'h7FFF_FFFF, 0, 1'b0);
    add_number(32'h8000_0000, 0, 1'b0);
    add_number(32'h8000_0001, 0, 1'b0);
    add_number(32'h7FFF_FFFE, 0, 1'b0);
    add_number(32'h5555_5555, 0, 1'b0);
    add_number(32'hAAAA_AAAA, 0, 1'b0);
    add_number(-32'sd9, 0, 1'b0);
    add_number(32'd12345, 0, 1'b0);
    add_number(-32'sd7, 0, 1'b1);

    // random: four pacing phases, each opened after a full drain
    for (int p = 0; p < 4; p++) begin
      for (int unsigned i = 0; i < RANDOM_ITEMS / 4; i++)
        add_number(pick_number(), pct_tab[p], i == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (number_q.size() != 0 || start || exp_text_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative), %0d characters checked,",
             numbers_sent, negatives_sent, chars_checked);
    $display("extremes, zero and four sender pacing phases; %0d mismatches", mismatches);
    if (mismatches == 0 && exp_text_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d numbers and %0d characters outstanding",
             $realtime, number_q.size(), exp_text_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
